FILE: rtl/core/ble_pkg.sv
// ----------------------------------------------------------------------------
// Battery level estimator package
// Shared widths, reset values, register indexes and structs.
// ----------------------------------------------------------------------------
package ble_pkg;

	localparam int SAMPLE_W           = 12;
	localparam int SUM_W              = 16;
	localparam int PCT_W              = 7;
	localparam int CFG_INDEX_W        = 3;
	localparam int WINDOW_SAMPLES_DEF = 10;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [PCT_W-1:0]    PCT_FULL   = 7'd100;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;

	localparam logic [SAMPLE_W-1:0] RST_RAW_LOW_BOUND    = 12'd1900;
	localparam logic [SAMPLE_W-1:0] RST_RAW_HIGH_BOUND   = 12'd2400;
	localparam logic [SAMPLE_W-1:0] RST_SPREAD_LIMIT     = 12'd80;
	localparam logic [SAMPLE_W-1:0] RST_CHARGE_THRESHOLD = 12'd2430;
	localparam logic [SAMPLE_W-1:0] RST_CHARGE_OFFSET    = 12'd40;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RAW_LOW_BOUND    = 3'd0,
		REG_RAW_HIGH_BOUND   = 3'd1,
		REG_SPREAD_LIMIT     = 3'd2,
		REG_CHARGE_THRESHOLD = 3'd3,
		REG_CHARGE_OFFSET    = 3'd4
	} ble_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] raw_low_bound;
		logic [SAMPLE_W-1:0] raw_high_bound;
		logic [SAMPLE_W-1:0] spread_limit;
		logic [SAMPLE_W-1:0] charge_threshold;
		logic [SAMPLE_W-1:0] charge_offset;
	} ble_cfg_t;

	// one finished window: sum, minimum and maximum
	typedef struct packed {
		logic [SUM_W-1:0]    win_sum;
		logic [SAMPLE_W-1:0] win_min;
		logic [SAMPLE_W-1:0] win_max;
	} ble_window_t;

	typedef struct packed {
		logic        valid;
		ble_window_t win;
	} ble_push_t;

endpackage

FILE: rtl/core/ble_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one ADC sample per transfer.
// ----------------------------------------------------------------------------
interface ble_sample_if;
	import ble_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

FILE: rtl/core/ble_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one window estimate per transfer.
// ----------------------------------------------------------------------------
interface ble_result_if;
	import ble_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] average;
	logic [SAMPLE_W-1:0] spread;
	logic                cell_absent;
	logic                charging;
	logic [PCT_W-1:0]    percent;

	modport source (output valid, output average, output spread, output cell_absent,
		output charging, output percent, input ready);
	modport sink (input valid, input average, input spread, input cell_absent,
		input charging, input percent, output ready);
endinterface

FILE: rtl/core/ble_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ble_cfg_if;
	import ble_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [SAMPLE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ble_queue.sv
// ----------------------------------------------------------------------------
// Window queue
// Short FIFO of finished windows between the accumulator and the estimator.
// ----------------------------------------------------------------------------
module ble_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  ble_pkg::ble_push_t  push,
	output logic                push_ready,
	output logic                pop_valid,
	output ble_pkg::ble_window_t pop_win,
	input  logic                pop_ready
);
	import ble_pkg::*;

	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(QUEUE_DEPTH);

	ble_window_t        mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_win    = mem[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/ble_front.sv
// ----------------------------------------------------------------------------
// Window accumulator
// Takes samples, keeps sum/min/max/count, pushes each finished window.
// ----------------------------------------------------------------------------
module ble_front #(
	parameter int WINDOW_SAMPLES = ble_pkg::WINDOW_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	ble_sample_if.sink         samples,
	input  logic               push_ready,
	output ble_pkg::ble_push_t push
);
	import ble_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
	localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(WINDOW_SAMPLES - 1);

	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [CNT_W-1:0]    count_q;

	logic                accept;
	logic                window_end;
	logic [SUM_W-1:0]    sum_next;
	logic [SAMPLE_W-1:0] min_next;
	logic [SAMPLE_W-1:0] max_next;

	assign samples.ready = push_ready;
	assign accept        = samples.valid && samples.ready;
	assign window_end    = (count_q == LAST_COUNT);

	assign sum_next = sum_q + SUM_W'(samples.sample);
	assign min_next = (samples.sample < min_q) ? samples.sample : min_q;
	assign max_next = (samples.sample > max_q) ? samples.sample : max_q;

	assign push.valid       = accept && window_end;
	assign push.win.win_sum = sum_next;
	assign push.win.win_min = min_next;
	assign push.win.win_max = max_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			min_q   <= SAMPLE_MAX;
			max_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (window_end) begin
				sum_q   <= '0;
				min_q   <= SAMPLE_MAX;
				max_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				min_q   <= min_next;
				max_q   <= max_next;
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/ble_back.sv
// ----------------------------------------------------------------------------
// Window estimator
// Average, spread, flags and percent map per window; owns the result register.
// ----------------------------------------------------------------------------
module ble_back #(
	parameter int WINDOW_SAMPLES = ble_pkg::WINDOW_SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ble_pkg::ble_cfg_t    cfg_regs,
	input  logic                 pop_valid,
	input  ble_pkg::ble_window_t pop_win,
	output logic                 pop_ready,
	ble_result_if.source         results
);
	import ble_pkg::*;

	// average by reciprocal: exact floor for any SUM_W-bit sum
	localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_SAMPLES);
	localparam int RECIP_W     = SUM_W + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(
		((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_SAMPLES) - 1) /
		longint'(WINDOW_SAMPLES));

	// quotient of the map is below 100, so PCT_W restoring steps do it
	localparam int DIV_STEPS = PCT_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int SCALED_W  = SAMPLE_W + PCT_W;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MAP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [PROD_W-1:0]      prod_q;
	logic [SAMPLE_W-1:0]    spread_q;
	logic signed [SAMPLE_W:0] v_q;
	logic [SAMPLE_W-1:0]    rem_q;
	logic [DIV_STEPS-1:0]   dq_q;
	logic [SAMPLE_W-1:0]    dvs_q;
	logic [STEP_W-1:0]      step_q;
	logic [SAMPLE_W-1:0]    avg_q;
	logic                   nobat_q;
	logic                   chg_q;
	logic [PCT_W-1:0]       map_q;
	logic [PCT_W-1:0]       last_clean_q;

	logic                   out_valid_q;
	logic [SAMPLE_W-1:0]    out_avg_q;
	logic [SAMPLE_W-1:0]    out_spread_q;
	logic                   out_nobat_q;
	logic                   out_chg_q;
	logic [PCT_W-1:0]       out_pct_q;

	logic [SAMPLE_W-1:0]    avg_w;
	logic                   nobat_w;
	logic                   chg_w;
	logic signed [SAMPLE_W:0] avg_s;
	logic signed [SAMPLE_W:0] v_w;
	logic signed [SAMPLE_W:0] lo_s;
	logic [SAMPLE_W-1:0]    diff_w;
	logic [SAMPLE_W-1:0]    span_w;
	logic                   bounds_ok;
	logic [SCALED_W-1:0]    scaled_w;
	logic [SAMPLE_W:0]      shifted_w;
	logic                   ge_w;
	logic [SAMPLE_W-1:0]    rem_next;
	logic [DIV_STEPS-1:0]   quo_next;
	logic [PCT_W-1:0]       pct_w;
	logic                   out_free;
	logic                   load_out;

	assign avg_w   = prod_q[RECIP_SHIFT +: SAMPLE_W];
	assign nobat_w = (spread_q > cfg_regs.spread_limit);
	assign chg_w   = nobat_w || (avg_w > cfg_regs.charge_threshold);
	assign avg_s   = $signed({1'b0, avg_w});
	assign v_w     = (chg_w && !nobat_w) ?
		(avg_s - $signed({1'b0, cfg_regs.charge_offset})) : avg_s;

	assign lo_s      = $signed({1'b0, cfg_regs.raw_low_bound});
	assign diff_w    = SAMPLE_W'(v_q - lo_s);
	assign span_w    = cfg_regs.raw_high_bound - cfg_regs.raw_low_bound;
	assign bounds_ok = (cfg_regs.raw_high_bound > cfg_regs.raw_low_bound);
	assign scaled_w  = SCALED_W'(diff_w) * SCALED_W'(PCT_FULL);

	assign shifted_w = {rem_q, dq_q[DIV_STEPS-1]};
	assign ge_w      = (shifted_w >= {1'b0, dvs_q});
	assign rem_next  = ge_w ? SAMPLE_W'(shifted_w - {1'b0, dvs_q}) : shifted_w[SAMPLE_W-1:0];
	assign quo_next  = {dq_q[DIV_STEPS-2:0], ge_w};

	// charging holds the percent at or above the last clean value
	assign pct_w = nobat_q ? PCT_FULL :
		((chg_q && (last_clean_q > map_q)) ? last_clean_q : map_q);

	assign out_free  = !out_valid_q || results.ready;
	assign load_out  = (state_q == ST_DONE) && out_free;
	assign pop_ready = (state_q == ST_IDLE);

	assign results.valid       = out_valid_q;
	assign results.average     = out_avg_q;
	assign results.spread      = out_spread_q;
	assign results.cell_absent = out_nobat_q;
	assign results.charging    = out_chg_q;
	assign results.percent     = out_pct_q;

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				prod_q   <= PROD_W'(pop_win.win_sum) * PROD_W'(RECIP_MULT);
				spread_q <= pop_win.win_max - pop_win.win_min;
			end
			ST_EVAL: begin
				v_q <= v_w;
			end
			ST_MAP: begin
				rem_q <= scaled_w[SCALED_W-1 -: SAMPLE_W];
				dq_q  <= scaled_w[DIV_STEPS-1:0];
				dvs_q <= span_w;
			end
			ST_DIV: begin
				rem_q <= rem_next;
				dq_q  <= quo_next;
			end
			default: begin
			end
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			avg_q        <= '0;
			nobat_q      <= 1'b0;
			chg_q        <= 1'b0;
			map_q        <= '0;
			last_clean_q <= '0;
			out_valid_q  <= 1'b0;
			out_avg_q    <= '0;
			out_spread_q <= '0;
			out_nobat_q  <= 1'b0;
			out_chg_q    <= 1'b0;
			out_pct_q    <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					avg_q   <= avg_w;
					nobat_q <= nobat_w;
					chg_q   <= chg_w;
					state_q <= ST_MAP;
				end
				ST_MAP: begin
					if (nobat_q) begin
						map_q   <= PCT_FULL;
						state_q <= ST_DONE;
					end else if (!bounds_ok) begin
						map_q   <= (v_q >= lo_s) ? PCT_FULL : '0;
						state_q <= ST_DONE;
					end else if (v_q <= lo_s) begin
						map_q   <= '0;
						state_q <= ST_DONE;
					end else if (diff_w >= span_w) begin
						map_q   <= PCT_FULL;
						state_q <= ST_DONE;
					end else begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						map_q   <= quo_next;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_avg_q    <= avg_q;
						out_spread_q <= spread_q;
						out_nobat_q  <= nobat_q;
						out_chg_q    <= chg_q;
						out_pct_q    <= pct_w;
						if (!chg_q) begin
							last_clean_q <= map_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/battery_level_estimator.sv
// ----------------------------------------------------------------------------
// Battery level estimator
// Windows of ADC samples reduced to average, spread, presence, charging and
// a percent estimate.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake     payload
//  samples   in   valid/ready   sample[11:0]
//  results   out  valid/ready   average, spread, cell_absent, charging, percent
//  cfg       in   valid/ready   index[2:0], data[11:0]   (ready tied high)
//
//  The accumulator takes one sample per cycle while the window queue has room.
//  The estimator takes one window at a time through its evaluate and map states,
//  with restoring percent divider steps when the offset-adjusted average falls
//  strictly inside the calibration range. Reset is asynchronous, with no clearing
//  pass, and clears control and result state; datapath and queue data are not reset.
//  A stalled result holds the output register and the estimator; the queue
//  then takes two more windows before samples stall.
//
module battery_level_estimator #(
	parameter int WINDOW_SAMPLES = ble_pkg::WINDOW_SAMPLES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ble_sample_if.sink   samples,
	ble_result_if.source results,
	ble_cfg_if.sink      cfg
);
	import ble_pkg::*;

	ble_cfg_t    cfg_q;
	ble_push_t   push;
	logic        push_ready;
	logic        pop_valid;
	ble_window_t pop_win;
	logic        pop_ready;

	// register file: writes always taken, unknown indexes dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_low_bound    <= RST_RAW_LOW_BOUND;
			cfg_q.raw_high_bound   <= RST_RAW_HIGH_BOUND;
			cfg_q.spread_limit     <= RST_SPREAD_LIMIT;
			cfg_q.charge_threshold <= RST_CHARGE_THRESHOLD;
			cfg_q.charge_offset    <= RST_CHARGE_OFFSET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RAW_LOW_BOUND:    cfg_q.raw_low_bound    <= cfg.data;
				REG_RAW_HIGH_BOUND:   cfg_q.raw_high_bound   <= cfg.data;
				REG_SPREAD_LIMIT:     cfg_q.spread_limit     <= cfg.data;
				REG_CHARGE_THRESHOLD: cfg_q.charge_threshold <= cfg.data;
				REG_CHARGE_OFFSET:    cfg_q.charge_offset    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// front: per-sample sum/min/max, one push per finished window
	ble_front #(
		.WINDOW_SAMPLES(WINDOW_SAMPLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.push_ready(push_ready),
		.push      (push)
	);

	// decouples window production from estimation
	ble_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_win   (pop_win),
		.pop_ready (pop_ready)
	);

	// back: average, flags, percent map, result register
	ble_back #(
		.WINDOW_SAMPLES(WINDOW_SAMPLES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_q),
		.pop_valid(pop_valid),
		.pop_win  (pop_win),
		.pop_ready(pop_ready),
		.results  (results)
	);

`ifndef SYNTHESIS
	// missing cell always reports charging at full scale
	a_nobat_full: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.cell_absent |-> results.charging &&
		(results.percent == PCT_FULL))
		else $error("cell_absent result without forced charging/full percent");

	// a clean window never shows a spread beyond the limit
	a_spread_ok: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.cell_absent |-> results.spread <= cfg_q.spread_limit)
		else $error("spread above limit without cell_absent");

	// non-charging windows stay at or below the charge threshold
	a_chg_thr: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.charging |-> results.average <= cfg_q.charge_threshold)
		else $error("average above threshold reported as not charging");

	// percent never exceeds full scale
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.percent <= PCT_FULL)
		else $error("percent above full scale");
`endif

endmodule
